[hdl/shce_pkg.sv]
// Shared widths, constants, types and table functions for the SH color evaluator.
package shce_pkg;

  // Field widths
  localparam int DIR_W      = 16;
  localparam int IDX_W      = 4;
  localparam int COEF_W     = 24;
  localparam int OUT_W      = 24;
  localparam int CFG_W      = 2;
  localparam int IN_DATA_W  = 3 * DIR_W + 3 * COEF_W;
  localparam int OUT_DATA_W = 3 * OUT_W;

  // Datapath widths
  localparam int PROD_W    = 2 * DIR_W;        // squares and cross products
  localparam int Q_W       = PROD_W + 2;       // quadratic forms
  localparam int CUB_W     = DIR_W + Q_W;      // cubic forms before rounding
  localparam int CUB_SHIFT = 14;
  localparam int P_W       = CUB_W - CUB_SHIFT; // polynomial, Q.28
  localparam int K_W       = 27;               // SH constants, Q.24
  localparam int PK_W      = P_W + K_W;
  localparam int BAS_SHIFT = 32;
  localparam int B_W       = 28;               // basis, Q.20
  localparam int LP_W      = B_W + COEF_W;     // basis times coefficient, Q.36
  localparam int TERM_SHIFT = 6;
  localparam int TERM_W    = LP_W - TERM_SHIFT; // accumulator term, Q.30
  localparam int ACC_W     = 48;
  localparam int SUM_W     = ACC_W + 1;
  localparam int OUT_SHIFT = 14;
  localparam int FIN_W     = SUM_W - OUT_SHIFT;

  // Pipeline depth
  localparam int BAS_STAGES = 6;
  localparam int PIPE_ITEMS = BAS_STAGES + 3;  // basis stages, product, final, output
  localparam int PEND_W     = $clog2(PIPE_ITEMS + 2);

  localparam logic [1:0] MAX_DEGREE = 2'd3;
  localparam logic [1:0] DEGREE_RST = 2'd3;

  // Rounding offsets and fixed values
  localparam logic signed [Q_W-1:0]   Q_ONE     = Q_W'(1) <<< 28;
  localparam logic signed [CUB_W-1:0] CUB_HALF  = CUB_W'(1) <<< (CUB_SHIFT - 1);
  localparam logic signed [PK_W-1:0]  PK_HALF   = PK_W'(1) <<< (BAS_SHIFT - 1);
  localparam logic signed [LP_W-1:0]  LP_HALF   = LP_W'(1) <<< (TERM_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] HALF_Q30  = SUM_W'(1) <<< 29;
  localparam logic signed [SUM_W-1:0] OUT_HALF  = SUM_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  // SH constants, Q.24 rounded
  localparam logic signed [K_W-1:0] K_C0  = 27'sd4732765;
  localparam logic signed [K_W-1:0] K_C1  = 27'sd8197390;
  localparam logic signed [K_W-1:0] K_C2A = 27'sd18329921;
  localparam logic signed [K_W-1:0] K_C2C = 27'sd5291392;
  localparam logic signed [K_W-1:0] K_C2E = 27'sd9164961;
  localparam logic signed [K_W-1:0] K_C3A = 27'sd9899289;
  localparam logic signed [K_W-1:0] K_C3B = 27'sd48496413;
  localparam logic signed [K_W-1:0] K_C3C = 27'sd7667956;
  localparam logic signed [K_W-1:0] K_C3D = 27'sd6260860;
  localparam logic signed [K_W-1:0] K_C3F = 27'sd24248206;

  // Coefficient index codes, band l, order m (M = minus, P = plus)
  localparam logic [IDX_W-1:0] SH_00  = 4'd0;
  localparam logic [IDX_W-1:0] SH_1M1 = 4'd1;
  localparam logic [IDX_W-1:0] SH_10  = 4'd2;
  localparam logic [IDX_W-1:0] SH_1P1 = 4'd3;
  localparam logic [IDX_W-1:0] SH_2M2 = 4'd4;
  localparam logic [IDX_W-1:0] SH_2M1 = 4'd5;
  localparam logic [IDX_W-1:0] SH_20  = 4'd6;
  localparam logic [IDX_W-1:0] SH_2P1 = 4'd7;
  localparam logic [IDX_W-1:0] SH_2P2 = 4'd8;
  localparam logic [IDX_W-1:0] SH_3M3 = 4'd9;
  localparam logic [IDX_W-1:0] SH_3M2 = 4'd10;
  localparam logic [IDX_W-1:0] SH_3M1 = 4'd11;
  localparam logic [IDX_W-1:0] SH_30  = 4'd12;
  localparam logic [IDX_W-1:0] SH_3P1 = 4'd13;
  localparam logic [IDX_W-1:0] SH_3P2 = 4'd14;
  localparam logic [IDX_W-1:0] SH_3P3 = 4'd15;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Side data that travels with an item through the basis pipeline
  typedef struct packed {
    coef_t coef_r;
    coef_t coef_g;
    coef_t coef_b;
    logic  last;
    logic  en;
  } tag_t;

  // Per-stage control handed to the lanes
  typedef struct packed {
    logic vld;
    logic last;
    logic en;
  } ctl_t;

  function automatic logic [1:0] band_of(input logic [IDX_W-1:0] idx);
    logic [1:0] band;
    if (idx == SH_00) begin
      band = 2'd0;
    end else if (idx inside {[SH_1M1:SH_1P1]}) begin
      band = 2'd1;
    end else if (idx inside {[SH_2M2:SH_2P2]}) begin
      band = 2'd2;
    end else begin
      band = 2'd3;
    end
    return band;
  endfunction

  function automatic logic signed [K_W-1:0] k_of(input logic [IDX_W-1:0] idx);
    logic signed [K_W-1:0] k;
    case (idx)
      SH_00:                       k = K_C0;
      SH_1M1, SH_10, SH_1P1:       k = K_C1;
      SH_2M2, SH_2M1, SH_2P1:      k = K_C2A;
      SH_20:                       k = K_C2C;
      SH_2P2:                      k = K_C2E;
      SH_3M3, SH_3P3:              k = K_C3A;
      SH_3M2:                      k = K_C3B;
      SH_3M1, SH_3P1:              k = K_C3C;
      SH_30:                       k = K_C3D;
      SH_3P2:                      k = K_C3F;
      default:                     k = K_C0;
    endcase
    return k;
  endfunction

endpackage

[hdl/sh_color_evaluator.sv]
// Top level of the spherical-harmonic color evaluator: ports, basis pipeline, lanes, output.
//
// Takes coefficient requests (index 0 is the DC term, index n is rest term n-1, with the view
// direction in Q1.14 and coefficients in Q7.16) and adds basis times coefficient into three
// per-channel accumulators; a request marked by in_tlast closes the splat and yields one Q8.16
// RGB result after the basis pipeline and the accumulate, final and output registers. The rate
// is one request per cycle while in_tready is high, set by the saturating accumulate in each
// channel lane; the basis itself runs in a six-stage pipeline of products, form selection,
// cubic product, rounding and constant scaling.
// A waiting result stalls the input only when another result is ready to follow it.
// sh_degree (reset 3) limits the bands used; coefficients above it add nothing. The user must
// write it through cfg_data only while no request is in flight; the block does not enforce it.
module sh_color_evaluator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: dir_x, dir_y, dir_z, coef_r, coef_g, coef_b (lowest bit first)
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [shce_pkg::IN_DATA_W-1:0]         in_tdata,
  // in_tuser: coef_index
  input  logic [shce_pkg::IDX_W-1:0]             in_tuser,
  input  logic                                   in_tlast,
  // out_tdata: red, green, blue (lowest bit first)
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [shce_pkg::OUT_DATA_W-1:0]        out_tdata,
  // cfg_data: sh_degree
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [shce_pkg::CFG_W-1:0]             cfg_data
);

  localparam int DW = shce_pkg::DIR_W;
  localparam int CW = shce_pkg::COEF_W;
  localparam int OW = shce_pkg::OUT_W;

  logic [shce_pkg::CFG_W-1:0] sh_degree_r;
  logic [1:0]                 limit;
  logic                       adv;
  shce_pkg::tag_t             in_tag;
  logic                       bas_vld;
  shce_pkg::tag_t             bas_tag;
  logic signed [shce_pkg::B_W-1:0] bas;
  shce_pkg::ctl_t             acc_ctl_r;
  logic                       fin_vld_r;
  logic                       out_vld_r;
  logic [shce_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [OW-1:0]              red, green, blue;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_degree_r <= shce_pkg::DEGREE_RST;
    end else if (cfg_valid) begin
      sh_degree_r <= cfg_data;
    end
  end

  assign limit = (sh_degree_r > shce_pkg::MAX_DEGREE) ? shce_pkg::MAX_DEGREE : sh_degree_r;

  // Pipeline moves unless a result waits and another is ready behind it
  assign adv       = !out_vld_r || out_tready || !fin_vld_r;
  assign in_tready = adv;

  // Request unpack
  always_comb begin
    in_tag.coef_r = in_tdata[3*DW +: CW];
    in_tag.coef_g = in_tdata[3*DW+CW +: CW];
    in_tag.coef_b = in_tdata[3*DW+2*CW +: CW];
    in_tag.last   = in_tlast;
    in_tag.en     = (shce_pkg::band_of(in_tuser) <= limit);
  end

  shce_basis u_basis (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (in_tvalid),
    .dir_x      (in_tdata[0 +: DW]),
    .dir_y      (in_tdata[DW +: DW]),
    .dir_z      (in_tdata[2*DW +: DW]),
    .coef_index (in_tuser),
    .in_tag     (in_tag),
    .bas_vld    (bas_vld),
    .bas_tag    (bas_tag),
    .bas        (bas)
  );

  // Control for the lanes' accumulate stage and the final stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_ctl_r <= '0;
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      acc_ctl_r.vld  <= bas_vld;
      acc_ctl_r.last <= bas_tag.last;
      acc_ctl_r.en   <= bas_tag.en;
      fin_vld_r      <= acc_ctl_r.vld && acc_ctl_r.last;
    end
  end

  shce_lane u_lane_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .bas     (bas),
    .coef    (bas_tag.coef_r),
    .acc_ctl (acc_ctl_r),
    .color   (red)
  );

  shce_lane u_lane_g (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .bas     (bas),
    .coef    (bas_tag.coef_g),
    .acc_ctl (acc_ctl_r),
    .color   (green)
  );

  shce_lane u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .bas     (bas),
    .coef    (bas_tag.coef_b),
    .acc_ctl (acc_ctl_r),
    .color   (blue)
  );

  // Merge the three channels into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && fin_vld_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_vld_r) begin
      out_data_r <= {blue, green, red};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

[hdl/shce_basis.sv]
// Six-stage pipeline that evaluates the real SH basis value of one index at a direction.
module shce_basis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_vld,
  input  logic signed [shce_pkg::DIR_W-1:0]   dir_x,
  input  logic signed [shce_pkg::DIR_W-1:0]   dir_y,
  input  logic signed [shce_pkg::DIR_W-1:0]   dir_z,
  input  logic        [shce_pkg::IDX_W-1:0]   coef_index,
  input  shce_pkg::tag_t                      in_tag,
  output logic                                bas_vld,
  output shce_pkg::tag_t                      bas_tag,
  output logic signed [shce_pkg::B_W-1:0]     bas
);

  // Valid and side data shift line
  logic [shce_pkg::BAS_STAGES-1:0] vld_r;
  shce_pkg::tag_t                  tag_r [shce_pkg::BAS_STAGES];

  // Stage 1: products of direction components
  logic signed [shce_pkg::DIR_W-1:0]  x_r, y_r, z_r;
  logic        [shce_pkg::IDX_W-1:0]  idx_r;
  logic signed [shce_pkg::PROD_W-1:0] xx_r, yy_r, zz_r, xy_r, yz_r, xz_r;

  // Stage 2: quadratic form, cubic multiplier, sign, constant
  logic signed [shce_pkg::Q_W-1:0]    q_nxt, q2_r;
  logic signed [shce_pkg::DIR_W-1:0]  m_nxt, m2_r;
  logic                               cub_nxt, cub2_r;
  logic                               neg_nxt, neg2_r;
  logic signed [shce_pkg::K_W-1:0]    k2_r;

  // Stage 3: cubic product
  logic signed [shce_pkg::CUB_W-1:0]  cub3_r;
  logic signed [shce_pkg::Q_W-1:0]    q3_r;
  logic                               is_cub3_r, neg3_r;
  logic signed [shce_pkg::K_W-1:0]    k3_r;

  // Stage 4: polynomial value
  logic signed [shce_pkg::CUB_W-1:0]  cub_rnd;
  logic signed [shce_pkg::P_W-1:0]    p_sel, p_nxt, p4_r;
  logic signed [shce_pkg::K_W-1:0]    k4_r;

  // Stage 5 and 6: scale by constant, round to Q.20
  logic signed [shce_pkg::PK_W-1:0]   pk5_r, pk_rnd;
  logic signed [shce_pkg::B_W-1:0]    bas6_r;

  // Quadratic terms brought to the form width
  logic signed [shce_pkg::Q_W-1:0] xx, yy, zz, xy, yz, xz, lx, ly, lz;

  // Control shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[shce_pkg::BAS_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= in_tag;
      for (int i = 1; i < shce_pkg::BAS_STAGES; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      x_r   <= dir_x;
      y_r   <= dir_y;
      z_r   <= dir_z;
      idx_r <= coef_index;
      xx_r  <= dir_x * dir_x;
      yy_r  <= dir_y * dir_y;
      zz_r  <= dir_z * dir_z;
      xy_r  <= dir_x * dir_y;
      yz_r  <= dir_y * dir_z;
      xz_r  <= dir_x * dir_z;
    end
  end

  // Stage 2: pick the form for this index
  always_comb begin
    xx = shce_pkg::Q_W'(xx_r);
    yy = shce_pkg::Q_W'(yy_r);
    zz = shce_pkg::Q_W'(zz_r);
    xy = shce_pkg::Q_W'(xy_r);
    yz = shce_pkg::Q_W'(yz_r);
    xz = shce_pkg::Q_W'(xz_r);
    lx = shce_pkg::Q_W'(x_r) <<< 14;
    ly = shce_pkg::Q_W'(y_r) <<< 14;
    lz = shce_pkg::Q_W'(z_r) <<< 14;
    m_nxt   = '0;
    cub_nxt = 1'b0;
    neg_nxt = 1'b0;
    case (idx_r)
      shce_pkg::SH_00:  q_nxt = shce_pkg::Q_ONE;
      shce_pkg::SH_1M1: begin q_nxt = ly; neg_nxt = 1'b1; end
      shce_pkg::SH_10:  q_nxt = lz;
      shce_pkg::SH_1P1: begin q_nxt = lx; neg_nxt = 1'b1; end
      shce_pkg::SH_2M2: q_nxt = xy;
      shce_pkg::SH_2M1: begin q_nxt = yz; neg_nxt = 1'b1; end
      shce_pkg::SH_20:  q_nxt = (zz <<< 1) - xx - yy;
      shce_pkg::SH_2P1: begin q_nxt = xz; neg_nxt = 1'b1; end
      shce_pkg::SH_2P2: q_nxt = xx - yy;
      shce_pkg::SH_3M3: begin
        q_nxt = (xx <<< 1) + xx - yy; m_nxt = y_r; cub_nxt = 1'b1; neg_nxt = 1'b1;
      end
      shce_pkg::SH_3M2: begin
        q_nxt = xy; m_nxt = z_r; cub_nxt = 1'b1;
      end
      shce_pkg::SH_3M1: begin
        q_nxt = (zz <<< 2) - xx - yy; m_nxt = y_r; cub_nxt = 1'b1; neg_nxt = 1'b1;
      end
      shce_pkg::SH_30: begin
        q_nxt = (zz <<< 1) - (xx <<< 1) - xx - (yy <<< 1) - yy;
        m_nxt = z_r; cub_nxt = 1'b1;
      end
      shce_pkg::SH_3P1: begin
        q_nxt = (zz <<< 2) - xx - yy; m_nxt = x_r; cub_nxt = 1'b1; neg_nxt = 1'b1;
      end
      shce_pkg::SH_3P2: begin
        q_nxt = xx - yy; m_nxt = z_r; cub_nxt = 1'b1;
      end
      shce_pkg::SH_3P3: begin
        q_nxt = xx - (yy <<< 1) - yy; m_nxt = x_r; cub_nxt = 1'b1; neg_nxt = 1'b1;
      end
      default: q_nxt = shce_pkg::Q_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_r   <= q_nxt;
      m2_r   <= m_nxt;
      cub2_r <= cub_nxt;
      neg2_r <= neg_nxt;
      k2_r   <= shce_pkg::k_of(idx_r);
    end
  end

  // Stage 3: third-order product
  always_ff @(posedge clk) begin
    if (adv) begin
      cub3_r    <= m2_r * q2_r;
      q3_r      <= q2_r;
      is_cub3_r <= cub2_r;
      neg3_r    <= neg2_r;
      k3_r      <= k2_r;
    end
  end

  // Stage 4: round cubic back to Q.28, apply sign
  always_comb begin
    cub_rnd = cub3_r + shce_pkg::CUB_HALF;
    p_sel   = is_cub3_r ? shce_pkg::P_W'(cub_rnd >>> shce_pkg::CUB_SHIFT)
                        : shce_pkg::P_W'(q3_r);
    p_nxt   = neg3_r ? -p_sel : p_sel;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r <= p_nxt;
      k4_r <= k3_r;
    end
  end

  // Stage 5: scale by constant
  always_ff @(posedge clk) begin
    if (adv) begin
      pk5_r <= p4_r * k4_r;
    end
  end

  // Stage 6: round to Q.20
  assign pk_rnd = pk5_r + shce_pkg::PK_HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      bas6_r <= shce_pkg::B_W'(pk_rnd >>> shce_pkg::BAS_SHIFT);
    end
  end

  assign bas_vld = vld_r[shce_pkg::BAS_STAGES-1];
  assign bas_tag = tag_r[shce_pkg::BAS_STAGES-1];
  assign bas     = bas6_r;

endmodule

[hdl/shce_lane.sv]
// One color channel: basis times coefficient, saturating accumulate, final round and clamp.
module shce_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic signed [shce_pkg::B_W-1:0]     bas,
  input  shce_pkg::coef_t                     coef,
  input  shce_pkg::ctl_t                      acc_ctl,
  output logic        [shce_pkg::OUT_W-1:0]   color
);

  logic signed [shce_pkg::LP_W-1:0]   prod_r;
  logic signed [shce_pkg::LP_W-1:0]   prod_rnd;
  logic signed [shce_pkg::TERM_W-1:0] term;
  logic signed [shce_pkg::SUM_W-1:0]  sum_full;
  logic signed [shce_pkg::ACC_W-1:0]  acc_sum;
  logic signed [shce_pkg::ACC_W-1:0]  acc_r;
  logic signed [shce_pkg::ACC_W-1:0]  fin_r;
  logic signed [shce_pkg::SUM_W-1:0]  fin_t, fin_rnd;
  logic        [shce_pkg::FIN_W-1:0]  fin_q;

  // Product stage
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= bas * coef;
    end
  end

  // Round to Q.30, gate by band enable, saturating add
  always_comb begin
    prod_rnd = prod_r + shce_pkg::LP_HALF;
    term     = acc_ctl.en ? shce_pkg::TERM_W'(prod_rnd >>> shce_pkg::TERM_SHIFT) : '0;
    sum_full = shce_pkg::SUM_W'(acc_r) + shce_pkg::SUM_W'(term);
    if (sum_full[shce_pkg::SUM_W-1] != sum_full[shce_pkg::ACC_W-1]) begin
      acc_sum = sum_full[shce_pkg::SUM_W-1] ? shce_pkg::ACC_MIN : shce_pkg::ACC_MAX;
    end else begin
      acc_sum = sum_full[shce_pkg::ACC_W-1:0];
    end
  end

  // Accumulator; cleared once a last request has been folded in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv && acc_ctl.vld) begin
      acc_r <= acc_ctl.last ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && acc_ctl.vld && acc_ctl.last) begin
      fin_r <= acc_sum;
    end
  end

  // Add 0.5, clamp at zero, round to Q8.16, saturate
  always_comb begin
    fin_t   = shce_pkg::SUM_W'(fin_r) + shce_pkg::HALF_Q30;
    fin_rnd = fin_t + shce_pkg::OUT_HALF;
    fin_q   = fin_rnd[shce_pkg::SUM_W-1:shce_pkg::OUT_SHIFT];
    if (fin_t[shce_pkg::SUM_W-1] || (fin_t == '0)) begin
      color = '0;
    end else if (|fin_q[shce_pkg::FIN_W-1:shce_pkg::OUT_W]) begin
      color = '1;
    end else begin
      color = fin_q[shce_pkg::OUT_W-1:0];
    end
  end

endmodule

[hdl/shce_checker.sv]
// Port-level checks for the SH color evaluator, bound to the top level.
module shce_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                in_tlast,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [shce_pkg::OUT_DATA_W-1:0]     out_tdata
);

  // Closing requests taken whose result has not been delivered yet
  logic [shce_pkg::PEND_W-1:0] pend_r;
  logic                        inc, dec;

  assign inc = in_tvalid && in_tready && in_tlast;
  assign dec = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + shce_pkg::PEND_W'(inc) - shce_pkg::PEND_W'(dec);
    end
  end

  // A result always has a closing request behind it
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pend_r != '0))
    else $error("result shown without a pending closing request");

  // No more open results than the pipeline can hold
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= shce_pkg::PEND_W'(shce_pkg::PIPE_ITEMS))
    else $error("more open results than pipeline stages");

  // An empty output register never holds back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register empty");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind sh_color_evaluator shce_checker u_shce_checker (.*);

[bench/tb_sh_color_evaluator.sv]
// Self-checking testbench for the spherical-harmonic color evaluator.
module tb_sh_color_evaluator;

  // Handshake timing and run bounds
  localparam int SETTLE     = 24;       // cycles for a request to clear the pipeline
  localparam int PHASE_REQS = 155;      // minimum requests per random phase
  localparam int N_PHASES   = 6;

  // SH constants in Q.24
  localparam longint KB0     = 4732765;
  localparam longint KB1     = 8197390;
  localparam longint KB2_XY  = 18329921;
  localparam longint KB2_ZZ  = 5291392;
  localparam longint KB2_XX  = 9164961;
  localparam longint KB3_A   = 9899289;
  localparam longint KB3_XYZ = 48496413;
  localparam longint KB3_C   = 7667956;
  localparam longint KB3_Z   = 6260860;
  localparam longint KB3_F   = 24248206;

  localparam longint SUM_HI  = (longint'(1) <<< 47) - 1;
  localparam longint SUM_LO  = -(longint'(1) <<< 47);
  localparam longint RGB_MAX = 16777215;

  localparam logic signed [shce_pkg::DIR_W-1:0]  DIR_MIN  =
    {1'b1, {(shce_pkg::DIR_W-1){1'b0}}};
  localparam logic signed [shce_pkg::DIR_W-1:0]  DIR_MAX  =
    {1'b0, {(shce_pkg::DIR_W-1){1'b1}}};
  localparam logic signed [shce_pkg::COEF_W-1:0] COEF_MIN =
    {1'b1, {(shce_pkg::COEF_W-1){1'b0}}};
  localparam logic signed [shce_pkg::COEF_W-1:0] COEF_MAX =
    {1'b0, {(shce_pkg::COEF_W-1){1'b1}}};

  typedef struct packed {
    logic signed [shce_pkg::DIR_W-1:0]  dir_x, dir_y, dir_z;
    logic [shce_pkg::IDX_W-1:0]         idx;
    logic signed [shce_pkg::COEF_W-1:0] coef_r, coef_g, coef_b;
    logic                               last;
  } coef_item_t;

  typedef struct packed {
    logic [shce_pkg::OUT_W-1:0] red, green, blue;
  } rgb_t;

  // One directed request: the item, the degree it runs under, and a typed
  // expectation where the color is obvious
  typedef struct packed {
    coef_item_t                 item;
    logic [shce_pkg::CFG_W-1:0] deg;
    logic                       typed;
    logic [shce_pkg::OUT_W-1:0] want;
  } probe_row_t;

  localparam probe_row_t PROBES [24] = '{
    // zero sum: only the half offset shows
    '{'{0, 0, 0, shce_pkg::SH_00, 0, 0, 0, 1'b1}, 2'd3, 1'b1, 24'd32768},
    // large negative DC clamps at zero
    '{'{0, 0, 0, shce_pkg::SH_00, COEF_MIN, COEF_MIN, COEF_MIN, 1'b1}, 2'd3, 1'b1, 24'd0},
    // extreme xyz term times most negative coefficient saturates high
    '{'{DIR_MIN, DIR_MIN, DIR_MIN, shce_pkg::SH_3M2, COEF_MIN, COEF_MIN, COEF_MIN, 1'b1},
      2'd3, 1'b1, 24'hFFFFFF},
    '{'{DIR_MIN, DIR_MIN, DIR_MIN, shce_pkg::SH_3M2, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1},
      2'd3, 1'b1, 24'd0},
    // unnormalized directions at the field extremes
    '{'{DIR_MAX, DIR_MAX, DIR_MAX, shce_pkg::SH_3P3, COEF_MAX, COEF_MIN, 12345, 1'b1},
      2'd3, 1'b0, 24'd0},
    '{'{DIR_MAX, DIR_MIN, 0, shce_pkg::SH_2P2, 400000, -400000, 0, 1'b1},
      2'd3, 1'b0, 24'd0},
    // one full splat, every index once
    '{'{9459, -9459, 9459, shce_pkg::SH_00,  65536,  32768,  98304, 1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_1M1, -20000, 15000,  40000, 1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_10,  30000, -25000,  10000, 1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_1P1, 12000,  8000,  -30000, 1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_2M2, -5000,  22000,  7000,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_2M1, 9000,  -9000,   18000, 1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_20,  14000,  3000,  -6000,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_2P1, -11000, 11000,  2500,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_2P2, 7500,  -2500,   16000, 1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_3M3, 4000,   6000,  -8000,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_3M2, -3000,  5000,   9000,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_3M1, 2000,  -7000,   1000,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_30,  6500,   4500,  -3500,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_3P1, -1500,  2500,   5500,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_3P2, 3300,  -4400,   2200,  1'b0}, 2'd3, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_3P3, 1200,   3400,  -5600,  1'b1}, 2'd3, 1'b0, 24'd0},
    // bands above the limit add nothing, a last mark still emits
    '{'{9459, -9459, 9459, shce_pkg::SH_2M1, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0},
      2'd0, 1'b0, 24'd0},
    '{'{9459, -9459, 9459, shce_pkg::SH_3P3, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1},
      2'd0, 1'b1, 24'd32768}
  };

  localparam logic [shce_pkg::CFG_W-1:0] PHASE_DEG [N_PHASES] =
    '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1};

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [shce_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [shce_pkg::IDX_W-1:0]      in_tuser   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [shce_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [shce_pkg::CFG_W-1:0]      cfg_data   = '0;

  // Predictor state
  longint                     sum_r, sum_g, sum_b;
  logic [shce_pkg::CFG_W-1:0] degree;
  rgb_t                       rgb_due [$];
  int                         sent_items;
  bit                         splat_open;

  int errors;
  int send_idle_pct;
  int recv_idle_pct;

  sh_color_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Round to nearest, ties up, of v / 2^s
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic int band_of_index(input logic [shce_pkg::IDX_W-1:0] idx);
    if (idx == shce_pkg::SH_00) return 0;
    if (idx <= shce_pkg::SH_1P1) return 1;
    if (idx <= shce_pkg::SH_2P2) return 2;
    return 3;
  endfunction

  // Real SH basis at the direction, Q.20
  function automatic longint sh_basis(input logic [shce_pkg::IDX_W-1:0] idx,
                                      input longint x, input longint y, input longint z);
    longint xx, yy, zz, p, k;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    case (idx)
      shce_pkg::SH_00:  begin p = longint'(1) <<< 28; k = KB0; end
      shce_pkg::SH_1M1: begin p = -y * 16384; k = KB1; end
      shce_pkg::SH_10:  begin p = z * 16384; k = KB1; end
      shce_pkg::SH_1P1: begin p = -x * 16384; k = KB1; end
      shce_pkg::SH_2M2: begin p = x * y; k = KB2_XY; end
      shce_pkg::SH_2M1: begin p = -(y * z); k = KB2_XY; end
      shce_pkg::SH_20:  begin p = 2 * zz - xx - yy; k = KB2_ZZ; end
      shce_pkg::SH_2P1: begin p = -(x * z); k = KB2_XY; end
      shce_pkg::SH_2P2: begin p = xx - yy; k = KB2_XX; end
      shce_pkg::SH_3M3: begin p = -round_shift(y * (3 * xx - yy), 14); k = KB3_A; end
      shce_pkg::SH_3M2: begin p = round_shift(x * y * z, 14); k = KB3_XYZ; end
      shce_pkg::SH_3M1: begin p = -round_shift(y * (4 * zz - xx - yy), 14); k = KB3_C; end
      shce_pkg::SH_30: begin
        p = round_shift(z * (2 * zz - 3 * xx - 3 * yy), 14);
        k = KB3_Z;
      end
      shce_pkg::SH_3P1: begin p = -round_shift(x * (4 * zz - xx - yy), 14); k = KB3_C; end
      shce_pkg::SH_3P2: begin p = round_shift(z * (xx - yy), 14); k = KB3_F; end
      default: begin p = -round_shift(x * (xx - 3 * yy), 14); k = KB3_A; end
    endcase
    return round_shift(p * k, 32);
  endfunction

  function automatic longint sat48(input longint s);
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  // Add the half, clamp at zero, round to Q8.16, saturate
  function automatic logic [shce_pkg::OUT_W-1:0] to_channel(input longint acc);
    longint t, r;
    t = acc + (longint'(1) <<< 29);
    if (t <= 0) return '0;
    r = round_shift(t, 14);
    if (r > RGB_MAX) r = RGB_MAX;
    return r[shce_pkg::OUT_W-1:0];
  endfunction

  // Update the predicted sums for one accepted request; queue the color on last
  function automatic void accumulate(input coef_item_t it, input logic typed,
                                     input logic [shce_pkg::OUT_W-1:0] want);
    longint b;
    rgb_t   rgb;
    if (band_of_index(it.idx) <= int'(degree)) begin
      b = sh_basis(it.idx, it.dir_x, it.dir_y, it.dir_z);
      sum_r = sat48(sum_r + round_shift(b * it.coef_r, 6));
      sum_g = sat48(sum_g + round_shift(b * it.coef_g, 6));
      sum_b = sat48(sum_b + round_shift(b * it.coef_b, 6));
    end
    if (it.last) begin
      if (typed) rgb = '{want, want, want};
      else rgb = '{to_channel(sum_r), to_channel(sum_g), to_channel(sum_b)};
      rgb_due.push_back(rgb);
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
    end
  endfunction

  function automatic logic signed [shce_pkg::DIR_W-1:0] rand_dir();
    case ($urandom_range(9))
      0: return DIR_MIN;
      1: return DIR_MAX;
      2: return '0;
      3, 4: return shce_pkg::DIR_W'($urandom);
      default: return shce_pkg::DIR_W'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [shce_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(9))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return shce_pkg::COEF_W'($urandom);
      default: return shce_pkg::COEF_W'(int'($urandom_range(524288)) - 262144);
    endcase
  endfunction

  // Offer one request after a random gap; valid stays high until accepted
  task automatic send_item(input coef_item_t it, input logic typed,
                           input logic [shce_pkg::OUT_W-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.coef_b, it.coef_g, it.coef_r, it.dir_z, it.dir_y, it.dir_x};
    in_tuser  <= it.idx;
    in_tlast  <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accumulate(it, typed, want);
    sent_items++;
    splat_open = !it.last;
  endtask

  // Drain everything, let the pipeline clear, then write the degree
  task automatic set_degree(input logic [shce_pkg::CFG_W-1:0] deg);
    in_tvalid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= deg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    degree = deg;
  endtask

  // Mostly ordered splats with random content, some saturating runs and noise
  task automatic run_phase(input int target);
    int                                start, kind, len, i;
    logic signed [shce_pkg::DIR_W-1:0] dx, dy, dz;
    logic [2:0]                        neg;
    coef_item_t                        it;
    start = sent_items;
    while (sent_items - start < target) begin
      kind = $urandom_range(99);
      dx = rand_dir();
      dy = rand_dir();
      dz = rand_dir();
      if (kind < 70) begin
        case ($urandom_range(3))
          0: len = 1;
          1: len = 4;
          2: len = 9;
          default: len = 16;
        endcase
        for (i = 0; i < len; i++) begin
          it = '{dx, dy, dz, shce_pkg::IDX_W'(i), rand_coef(), rand_coef(), rand_coef(),
                 i == len - 1};
          send_item(it, 1'b0, '0);
        end
      end else if (kind < 75) begin
        // drive the sums into the 48-bit limit
        neg = 3'($urandom);
        for (i = 0; i < 48; i++) begin
          it = '{DIR_MIN, DIR_MIN, DIR_MIN, shce_pkg::SH_3M2,
                 neg[0] ? COEF_MIN : COEF_MAX, neg[1] ? COEF_MIN : COEF_MAX,
                 neg[2] ? COEF_MIN : COEF_MAX, i == 47};
          send_item(it, 1'b0, '0);
        end
      end else begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) begin
          it = '{rand_dir(), rand_dir(), rand_dir(), shce_pkg::IDX_W'($urandom),
                 rand_coef(), rand_coef(), rand_coef(), $urandom_range(2) == 0};
          send_item(it, 1'b0, '0);
        end
      end
    end
    // close a splat left open so the degree change starts clean
    if (splat_open) begin
      it = '{dx, dy, dz, shce_pkg::SH_00, rand_coef(), rand_coef(), rand_coef(), 1'b1};
      send_item(it, 1'b0, '0);
    end
  endtask

  // Result side: random backpressure and in-order check
  always @(posedge clk) begin
    rgb_t exp_rgb;
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (rgb_due.size() == 0) begin
        $display("%0t: color with none expected, got %h", $time, out_tdata);
        errors++;
      end else begin
        exp_rgb = rgb_due.pop_front();
        if (out_tdata[shce_pkg::OUT_W-1:0] !== exp_rgb.red ||
            out_tdata[2*shce_pkg::OUT_W-1:shce_pkg::OUT_W] !== exp_rgb.green ||
            out_tdata[3*shce_pkg::OUT_W-1:2*shce_pkg::OUT_W] !== exp_rgb.blue) begin
          $display("%0t: color expected r=%h g=%h b=%h actual r=%h g=%h b=%h", $time,
                   exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                   out_tdata[shce_pkg::OUT_W-1:0],
                   out_tdata[2*shce_pkg::OUT_W-1:shce_pkg::OUT_W],
                   out_tdata[3*shce_pkg::OUT_W-1:2*shce_pkg::OUT_W]);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int i, ph;
    errors        = 0;
    sent_items    = 0;
    splat_open    = 1'b0;
    sum_r         = 0;
    sum_g         = 0;
    sum_b         = 0;
    degree        = shce_pkg::DEGREE_RST;
    send_idle_pct = 30;
    recv_idle_pct = 83;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_degree(2'd3);

    // directed table
    for (i = 0; i < 24; i++) begin
      if (PROBES[i].deg != degree) set_degree(PROBES[i].deg);
      send_item(PROBES[i].item, PROBES[i].typed, PROBES[i].want);
    end

    // random phases: sender idles less first, then receiver, then neither
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 83;
      end else if (ph < 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_degree(PHASE_DEG[ph]);
      run_phase(PHASE_REQS);
    end

    in_tvalid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("sh_color_evaluator: match");
    else
      $display("sh_color_evaluator: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("sh_color_evaluator: mismatch");
    $finish;
  end

endmodule
